// ===== hdl/tga_rle_pkg.sv =====
// Shared types, codes and pixel conversion helpers for the TGA RLE scanline decoder.
`timescale 1ns / 1ps

package tga_rle_pkg;

  // Request kinds on the input stream.
  typedef enum logic [1:0] {
    OP_BYTE      = 2'd0,
    OP_PAL_WRITE = 2'd1,
    OP_START     = 2'd2,
    OP_NONE      = 2'd3
  } op_e;

  // Pixel formats; codes above FMT_PALETTE decode as palette index too.
  typedef enum logic [2:0] {
    FMT_RGB555  = 3'd0,
    FMT_RGB24   = 3'd1,
    FMT_BGRA32  = 3'd2,
    FMT_GREY    = 3'd3,
    FMT_PALETTE = 3'd4
  } fmt_e;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_PIXEL_FORMAT    = 3'd0,
    CFG_COMPRESSED      = 3'd1,
    CFG_ROW_WIDTH       = 3'd2,
    CFG_FIRST_COLOR     = 3'd3,
    CFG_PALETTE_ENTRIES = 3'd4
  } cfg_idx_e;

  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [16:0] FULL_ROW   = 17'h10000;
  localparam int unsigned HDR_RUN_BIT = 7;

  typedef struct packed {
    logic [2:0]  pixel_format;
    logic        compressed;
    logic [15:0] row_width;
    logic [15:0] first_color;
    logic [8:0]  palette_entries;
  } cfg_t;

  // One result as it leaves the decode stage.
  typedef struct packed {
    logic        valid;
    logic [31:0] pixel;
    logic [7:0]  repeat_res;
    logic        row_end;
    logic        error;
    logic        pal_sel;   // pixel comes from the palette read
    logic        pal_hit;   // palette index inside the valid range
  } res_t;

  typedef struct packed {
    logic        wr_en;
    logic [7:0]  wr_addr;
    logic [31:0] wr_data;
    logic        rd_en;
    logic [7:0]  rd_addr;
  } pal_req_t;

  // floor(c * 255 / 31) for a 5-bit channel
  localparam logic [7:0] WIDEN5 [32] = '{
    8'd0,   8'd8,   8'd16,  8'd24,  8'd32,  8'd41,  8'd49,  8'd57,
    8'd65,  8'd74,  8'd82,  8'd90,  8'd98,  8'd106, 8'd115, 8'd123,
    8'd131, 8'd139, 8'd148, 8'd156, 8'd164, 8'd172, 8'd180, 8'd189,
    8'd197, 8'd205, 8'd213, 8'd222, 8'd230, 8'd238, 8'd246, 8'd255
  };

  // Direct-color conversion; palette formats are resolved elsewhere.
  function automatic logic [31:0] cvt_pixel(input logic [2:0] fmt, input logic [23:0] acc,
                                            input logic [7:0] last);
    logic [15:0] v;
    logic [31:0] p;
    v = {last, acc[7:0]};
    case (fmt)
      FMT_RGB555: p = {8'hff, WIDEN5[v[4:0]], WIDEN5[v[9:5]], WIDEN5[v[14:10]]};
      FMT_RGB24:  p = {8'hff, acc[7:0], acc[15:8], last};
      FMT_BGRA32: p = {last, acc[7:0], acc[15:8], acc[23:16]};
      FMT_GREY:   p = {8'hff, last, last, last};
      default:    p = '0;
    endcase
    return p;
  endfunction

  // Bytes per pixel for a format code.
  function automatic logic [2:0] pixel_bytes(input logic [2:0] fmt);
    logic [2:0] n;
    case (fmt)
      FMT_RGB555: n = 3'd2;
      FMT_RGB24:  n = 3'd3;
      FMT_BGRA32: n = 3'd4;
      default:    n = 3'd1;
    endcase
    return n;
  endfunction

endpackage

// ===== hdl/tga_rle_palette.sv =====
// Palette memory: one write port, one registered read port.
`timescale 1ns / 1ps

module tga_rle_palette #(
  parameter int unsigned DEPTH = 256
) (
  input  logic                clk_i,
  input  tga_rle_pkg::pal_req_t req_i,
  output logic [31:0]         rd_data_o
);
  import tga_rle_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);

  logic [31:0] mem [DEPTH];
  logic [31:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.wr_addr[AW-1:0]] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_data_q <= mem[req_i.rd_addr[AW-1:0]];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== hdl/tga_rle_decode.sv =====
// Packet parser, pixel assembly and column tracking, one request per cycle when fired.
`timescale 1ns / 1ps

module tga_rle_decode #(
  parameter int unsigned PALETTE_DEPTH = 256
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  fire_i,
  input  tga_rle_pkg::cfg_t     cfg_i,
  input  logic [1:0]            op_i,
  input  logic [7:0]            data_byte_i,
  input  logic [7:0]            pal_index_i,
  input  logic [31:0]           pal_color_i,
  output tga_rle_pkg::res_t     res_o,
  output tga_rle_pkg::pal_req_t pal_req_o
);
  import tga_rle_pkg::*;

  localparam logic [8:0] DEPTH_W = 9'(PALETTE_DEPTH);

  logic [23:0] acc_q, acc_d;
  logic [1:0]  bip_q, bip_d;
  logic        exp_hdr_q, exp_hdr_d;
  logic [7:0]  pkt_rem_q, pkt_rem_d;
  logic        pkt_run_q, pkt_run_d;
  logic [7:0]  run_len_q, run_len_d;
  logic [15:0] col_q, col_d;
  logic        err_q, err_d;

  logic [16:0] eff_width;
  logic [7:0]  hdr_count;
  logic [16:0] hdr_sum;
  logic [7:0]  emit_count;
  logic [16:0] emit_sum;
  logic        emit_end;
  logic [15:0] pal_diff;
  logic        pal_hit;
  logic        pal_fmt;
  logic [2:0]  bip_inc;

  assign eff_width = (cfg_i.row_width == '0) ? FULL_ROW : {1'b0, cfg_i.row_width};
  assign hdr_count = {1'b0, data_byte_i[6:0]} + 8'd1;
  assign hdr_sum   = {1'b0, col_q} + {9'd0, hdr_count};
  assign bip_inc   = {1'b0, bip_q} + 3'd1;

  // Palette index is only meaningful when byte >= first_color, then it fits in 8 bits.
  assign pal_diff = {8'd0, data_byte_i} - cfg_i.first_color;
  assign pal_hit  = ({8'd0, data_byte_i} >= cfg_i.first_color)
                 && ({1'b0, pal_diff[7:0]} < cfg_i.palette_entries)
                 && ({1'b0, pal_diff[7:0]} < DEPTH_W);
  assign pal_fmt  = (cfg_i.pixel_format >= FMT_PALETTE);

  assign emit_count = !cfg_i.compressed ? 8'd1 : (pkt_run_q ? run_len_q : 8'd1);
  assign emit_sum   = {1'b0, col_q} + {9'd0, emit_count};
  assign emit_end   = (emit_sum >= eff_width);

  always_comb begin
    acc_d     = acc_q;
    bip_d     = bip_q;
    exp_hdr_d = exp_hdr_q;
    pkt_rem_d = pkt_rem_q;
    pkt_run_d = pkt_run_q;
    run_len_d = run_len_q;
    col_d     = col_q;
    err_d     = err_q;
    res_o     = '0;

    pal_req_o.wr_en   = 1'b0;
    pal_req_o.wr_addr = pal_index_i;
    pal_req_o.wr_data = pal_color_i;
    pal_req_o.rd_en   = fire_i;
    pal_req_o.rd_addr = pal_diff[7:0];

    case (op_i)
      OP_PAL_WRITE: begin
        pal_req_o.wr_en = fire_i && ({1'b0, pal_index_i} < DEPTH_W);
      end
      OP_START: begin
        acc_d     = '0;
        bip_d     = '0;
        exp_hdr_d = 1'b1;
        pkt_rem_d = '0;
        pkt_run_d = 1'b0;
        run_len_d = '0;
        col_d     = '0;
        err_d     = 1'b0;
      end
      OP_BYTE: begin
        if (!err_q) begin
          if (cfg_i.compressed && exp_hdr_q) begin
            if (hdr_sum > eff_width) begin
              // overrun: drop the packet, flag it once
              err_d       = 1'b1;
              res_o.valid = 1'b1;
              res_o.error = 1'b1;
            end else begin
              exp_hdr_d = 1'b0;
              bip_d     = '0;
              acc_d     = '0;
              if (data_byte_i[HDR_RUN_BIT]) begin
                pkt_run_d = 1'b1;
                run_len_d = hdr_count;
                pkt_rem_d = 8'd1;
              end else begin
                pkt_run_d = 1'b0;
                run_len_d = '0;
                pkt_rem_d = hdr_count;
              end
            end
          end else if (bip_inc < pixel_bytes(cfg_i.pixel_format)) begin
            case (bip_q)
              2'd0:    acc_d = acc_q | {16'd0, data_byte_i};
              2'd1:    acc_d = acc_q | {8'd0, data_byte_i, 8'd0};
              2'd2:    acc_d = acc_q | {data_byte_i, 16'd0};
              default: acc_d = acc_q;
            endcase
            bip_d = bip_inc[1:0];
          end else begin
            acc_d = '0;
            bip_d = '0;
            res_o.valid      = 1'b1;
            res_o.pixel      = cvt_pixel(cfg_i.pixel_format, acc_q, data_byte_i);
            res_o.repeat_res = emit_count;
            res_o.row_end    = emit_end;
            res_o.pal_sel    = pal_fmt;
            res_o.pal_hit    = pal_hit;
            col_d = emit_end ? '0 : emit_sum[15:0];
            if (cfg_i.compressed) begin
              if (pkt_run_q) begin
                pkt_run_d = 1'b0;
                run_len_d = '0;
                pkt_rem_d = '0;
                exp_hdr_d = 1'b1;
              end else begin
                pkt_rem_d = (pkt_rem_q != '0) ? pkt_rem_q - 8'd1 : '0;
                if (pkt_rem_d == '0) begin
                  exp_hdr_d = 1'b1;
                end
              end
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q     <= '0;
      bip_q     <= '0;
      exp_hdr_q <= 1'b1;
      pkt_rem_q <= '0;
      pkt_run_q <= 1'b0;
      run_len_q <= '0;
      col_q     <= '0;
      err_q     <= 1'b0;
    end else if (fire_i) begin
      acc_q     <= acc_d;
      bip_q     <= bip_d;
      exp_hdr_q <= exp_hdr_d;
      pkt_rem_q <= pkt_rem_d;
      pkt_run_q <= pkt_run_d;
      run_len_q <= run_len_d;
      col_q     <= col_d;
      err_q     <= err_d;
    end
  end

endmodule

// ===== hdl/tga_rle_scanline_decoder_unit.sv =====
// Top level: TGA RLE scanline decoder with input register, result register and config port.
//
//   channel   direction  accept                          payload
//   s_axis    in         s_axis_tvalid_i & tready_o      tuser op, tdata byte/index/color
//   m_axis    out        m_axis_tvalid_o & tready_i      tdata pixel/repeat, tlast, tuser error
//   cfg       in         cfg_valid_i & cfg_ready_o       cfg_index_i, cfg_data_i
//
// One request per cycle sustained while the output is not stalled; a request passes the
// input register, then decode into the result register, beside the registered palette read.
// The palette memory read port sets the second stage boundary.
// Reset clears the parser state and the valid flags; palette contents are not cleared.
// A stalled output holds its result and the input register; one request waits per stage.
`timescale 1ns / 1ps

module tga_rle_scanline_decoder_unit #(
  parameter int unsigned PALETTE_DEPTH = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [47:0] s_axis_tdata_i,   // data_byte [7:0], pal_index [15:8], pal_color [47:16]
  input  logic [1:0]  s_axis_tuser_i,   // op [1:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,   // pixel [31:0], repeat_res [39:32]
  output logic        m_axis_tlast_o,   // row_end
  output logic [0:0]  m_axis_tuser_o,   // error [0]
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [tga_rle_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import tga_rle_pkg::*;

  cfg_t     cfg_q;
  res_t     res;
  pal_req_t pal_req;
  logic [31:0] pal_rd_data;

  logic        in_v_q;
  logic [1:0]  in_op_q;
  logic [7:0]  in_byte_q;
  logic [7:0]  in_pidx_q;
  logic [31:0] in_pcol_q;

  logic        out_v_q;
  logic [31:0] out_pix_q;
  logic [7:0]  out_rep_q;
  logic        out_end_q;
  logic        out_err_q;
  logic        out_psel_q;
  logic        out_phit_q;

  logic out_free;
  logic fire;

  assign out_free        = !out_v_q || m_axis_tready_i;
  assign fire            = in_v_q && out_free;
  assign s_axis_tready_o = !in_v_q || out_free;
  assign cfg_ready_o     = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pixel_format    <= FMT_BGRA32;
      cfg_q.compressed      <= 1'b0;
      cfg_q.row_width       <= 16'd1;
      cfg_q.first_color     <= '0;
      cfg_q.palette_entries <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_PIXEL_FORMAT:    cfg_q.pixel_format    <= cfg_data_i[2:0];
        CFG_COMPRESSED:      cfg_q.compressed      <= cfg_data_i[0];
        CFG_ROW_WIDTH:       cfg_q.row_width       <= cfg_data_i[15:0];
        CFG_FIRST_COLOR:     cfg_q.first_color     <= cfg_data_i[15:0];
        CFG_PALETTE_ENTRIES: cfg_q.palette_entries <= cfg_data_i[8:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_v_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_op_q   <= s_axis_tuser_i;
      in_byte_q <= s_axis_tdata_i[7:0];
      in_pidx_q <= s_axis_tdata_i[15:8];
      in_pcol_q <= s_axis_tdata_i[47:16];
    end
  end

  tga_rle_decode #(
    .PALETTE_DEPTH(PALETTE_DEPTH)
  ) u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .cfg_i       (cfg_q),
    .op_i        (in_op_q),
    .data_byte_i (in_byte_q),
    .pal_index_i (in_pidx_q),
    .pal_color_i (in_pcol_q),
    .res_o       (res),
    .pal_req_o   (pal_req)
  );

  tga_rle_palette #(
    .DEPTH(PALETTE_DEPTH)
  ) u_palette (
    .clk_i     (clk_i),
    .req_i     (pal_req),
    .rd_data_o (pal_rd_data)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (fire) begin
      out_v_q <= res.valid;
    end else if (m_axis_tready_i) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_pix_q  <= res.pixel;
      out_rep_q  <= res.repeat_res;
      out_end_q  <= res.row_end;
      out_err_q  <= res.error;
      out_psel_q <= res.pal_sel;
      out_phit_q <= res.pal_hit;
    end
  end

  assign m_axis_tvalid_o      = out_v_q;
  assign m_axis_tdata_o[31:0] = out_psel_q ? (out_phit_q ? pal_rd_data : 32'd0) : out_pix_q;
  assign m_axis_tdata_o[39:32] = out_rep_q;
  assign m_axis_tlast_o       = out_end_q;
  assign m_axis_tuser_o       = out_err_q;

endmodule
